// ===== hw/rtl/rsenc_pkg.sv =====
// Shared types, constants and GF(2^10) helpers for the Reed-Solomon encoder.
`timescale 1ns / 1ps

package rsenc_pkg;

  localparam int SYM_W   = 10;
  localparam int NCHECK  = 8;
  localparam int NECC    = 10;
  localparam int ECC_W   = SYM_W * NCHECK;
  localparam int IDX_W   = 4;
  localparam int FLUSH_W = 3;

  localparam logic [SYM_W-1:0] GF_POLY  = 10'h009;  // x^10 + x^3 + 1, top bit implied
  localparam logic [IDX_W-1:0] LAST_IDX = 4'd9;

  // generator exponents, feeding stages 7 down to 0
  localparam logic [SYM_W-1:0] GEN_EXP [NCHECK] = '{
    10'h21c, 10'h181, 10'h18e, 10'h25f, 10'h197, 10'h193, 10'h237, 10'h024
  };

  typedef enum logic [1:0] {
    ST_RUN,
    ST_FLUSH,
    ST_LOAD
  } state_t;

  typedef struct packed {
    logic             shift_in;
    logic             shift_zero;
    logic             load_out;
    logic [IDX_W-1:0] byte_sel;
  } dp_cmd_t;

  function automatic logic [SYM_W-1:0] gf_times_x(input logic [SYM_W-1:0] v);
    logic [SYM_W-1:0] r;
    r = {v[SYM_W-2:0], 1'b0};
    if (v[SYM_W-1]) begin
      r = r ^ GF_POLY;
    end
    return r;
  endfunction

  function automatic logic [SYM_W-1:0] gf_mul(input logic [SYM_W-1:0] a,
                                               input logic [SYM_W-1:0] b);
    logic [SYM_W-1:0] acc;
    acc = '0;
    for (int i = SYM_W - 1; i >= 0; i--) begin
      acc = gf_times_x(acc);
      if (b[i]) begin
        acc = acc ^ a;
      end
    end
    return acc;
  endfunction

  // alpha^e by square and multiply, elaboration only
  function automatic logic [SYM_W-1:0] gf_pow_alpha(input logic [SYM_W-1:0] e);
    logic [SYM_W-1:0] res;
    logic [SYM_W-1:0] base;
    res  = 10'd1;
    base = 10'd2;
    for (int i = 0; i < SYM_W; i++) begin
      if (e[i]) begin
        res = gf_mul(res, base);
      end
      base = gf_mul(base, base);
    end
    return res;
  endfunction

  localparam logic [SYM_W-1:0] GEN_COEF [NCHECK] = '{
    gf_pow_alpha(GEN_EXP[0]), gf_pow_alpha(GEN_EXP[1]),
    gf_pow_alpha(GEN_EXP[2]), gf_pow_alpha(GEN_EXP[3]),
    gf_pow_alpha(GEN_EXP[4]), gf_pow_alpha(GEN_EXP[5]),
    gf_pow_alpha(GEN_EXP[6]), gf_pow_alpha(GEN_EXP[7])
  };

endpackage

// ===== hw/rtl/rsenc_datapath.sv =====
// LFSR check-symbol datapath and packed ECC output register.
`timescale 1ns / 1ps

module rsenc_datapath
  import rsenc_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  dp_cmd_t       cmd,
  input  logic [7:0]    data_byte,
  output logic [7:0]    ecc_byte
);

  logic [SYM_W-1:0] lfsr      [NCHECK];
  logic [SYM_W-1:0] lfsr_next [NCHECK];
  logic [ECC_W-1:0] ecc_reg;
  logic [SYM_W-1:0] din;
  logic [SYM_W-1:0] top;

  assign top = lfsr[NCHECK-1];
  assign din = cmd.shift_in ? {2'b00, data_byte} : '0;

  always_comb begin
    for (int s = 1; s < NCHECK; s++) begin
      lfsr_next[s] = lfsr[s-1] ^ gf_mul(top, GEN_COEF[NCHECK-1-s]);
    end
    lfsr_next[0] = din ^ gf_mul(top, GEN_COEF[NCHECK-1]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < NCHECK; s++) begin
        lfsr[s] <= '0;
      end
    end else if (cmd.load_out) begin
      for (int s = 0; s < NCHECK; s++) begin
        lfsr[s] <= '0;
      end
    end else if (cmd.shift_in || cmd.shift_zero) begin
      lfsr <= lfsr_next;
    end
  end

  // c0 in the low bits, c7 in the high bits
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      for (int s = 0; s < NCHECK; s++) begin
        ecc_reg[s*SYM_W +: SYM_W] <= lfsr[s];
      end
    end
  end

  assign ecc_byte = ecc_reg[{cmd.byte_sel, 3'b000} +: 8];

endmodule

// ===== hw/rtl/rsenc_ctrl.sv =====
// Controller: page sequencing, flush count and ECC output counter.
`timescale 1ns / 1ps

module rsenc_ctrl
  import rsenc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_last,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_last,
  output logic [IDX_W-1:0] out_idx,
  output dp_cmd_t          cmd
);

  state_t               state;
  state_t               state_next;
  logic [FLUSH_W-1:0]   flush_cnt;
  logic                 out_busy;

  always_comb begin
    state_next = state;
    case (state)
      ST_RUN: begin
        if (in_valid && in_last) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (flush_cnt == FLUSH_W'(NCHECK - 1)) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (!out_busy) begin
          state_next = ST_RUN;
        end
      end
      default: state_next = ST_RUN;
    endcase
  end

  always_comb begin
    in_ready       = 1'b0;
    cmd.shift_in   = 1'b0;
    cmd.shift_zero = 1'b0;
    cmd.load_out   = 1'b0;
    cmd.byte_sel   = out_idx;
    case (state)
      ST_RUN: begin
        in_ready     = 1'b1;
        cmd.shift_in = in_valid;
      end
      ST_FLUSH: begin
        cmd.shift_zero = 1'b1;
      end
      ST_LOAD: begin
        cmd.load_out = !out_busy;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_RUN;
      flush_cnt <= '0;
    end else begin
      state     <= state_next;
      flush_cnt <= (state == ST_FLUSH) ? flush_cnt + 1'b1 : '0;
    end
  end

  // output side drains the latched ECC word while the next page streams in
  always_ff @(posedge clk) begin
    if (rst) begin
      out_busy <= 1'b0;
      out_idx  <= '0;
    end else if (cmd.load_out) begin
      out_busy <= 1'b1;
      out_idx  <= '0;
    end else if (out_busy && out_ready) begin
      if (out_idx == LAST_IDX) begin
        out_busy <= 1'b0;
        out_idx  <= '0;
      end else begin
        out_idx <= out_idx + 1'b1;
      end
    end
  end

  assign out_valid = out_busy;
  assign out_last  = (out_idx == LAST_IDX);

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !out_busy)
    else $error("ECC word latched while previous word still draining");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    out_idx <= LAST_IDX)
    else $error("ECC byte index out of range");

  a_last_starts_flush: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_last) |=> (state == ST_FLUSH && flush_cnt == '0))
    else $error("final byte did not start flush");

  a_flush_len: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FLUSH && flush_cnt == FLUSH_W'(NCHECK - 1)) |=> state == ST_LOAD)
    else $error("flush did not end after eight shifts");

endmodule

// ===== hw/rtl/rs_encoder_gf1024_8check.sv =====
// Top level: systematic RS encoder over GF(2^10), 8 check symbols, byte stream in and out.
// Input: one byte per cycle while running; a page of N bytes occupies the input for its N byte transfers,
// 8 LFSR flush shifts and the latch of the check word, which waits until the previous ECC word has drained.
// Output: once the check word is latched, 10 ECC bytes, one per cycle under tready; draining overlaps
// the next page, which stalls only at its own latch step.
// Reset (rst, synchronous, active high) clears the LFSR, the sequencer and the output counter.
`timescale 1ns / 1ps

module rs_encoder_gf1024_8check
  import rsenc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,   // last_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] ecc_byte, [11:8] ecc_index, [15:12] zero
  output logic        m_tlast    // last_ecc
);

  dp_cmd_t          cmd;
  logic [7:0]       ecc_byte;
  logic [IDX_W-1:0] ecc_index;

  rsenc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_last   (s_tlast),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_last  (m_tlast),
    .out_idx   (ecc_index),
    .cmd       (cmd)
  );

  rsenc_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .data_byte (s_tdata),
    .ecc_byte  (ecc_byte)
  );

  assign m_tdata = {4'b0000, ecc_index, ecc_byte};

endmodule
